// ===== hw/rtl/mau_pkg.sv =====
// Package for the modular arithmetic unit: widths, operation codes and shared types.
// No dependencies.
`default_nettype none
package mau_pkg;
	localparam int RW = 31;
	localparam int EW = 32;
	localparam int QDEPTH = 2;
	localparam logic [RW-1:0] MOD_RESET = RW'(1000000007);
	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_POW = 3'd4
	} op_t;
	typedef enum logic [1:0] {
		CL_DIRECT = 2'd0,
		CL_MUL = 2'd1,
		CL_POW = 2'd2,
		CL_DIV = 2'd3
	} cls_t;
	typedef struct packed {
		cls_t cls;
		logic [RW-1:0] a;
		logic [EW-1:0] b;
		logic [RW-1:0] r;
	} job_t;
	typedef enum logic [3:0] {
		ST_IDLE, ST_RA, ST_RB, ST_DISP, ST_MUL, ST_PSTEP, ST_PMUL, ST_PSQR,
		ST_DIVMUL, ST_DONE
	} st_t;
endpackage
`default_nettype wire

// ===== hw/rtl/modular_arithmetic_unit.sv =====
// Modular arithmetic unit: result residues over a configurable modulus.
// Top level; depends on mau_pkg, mau_front, mau_queue and mau_back.
//
// Requests enter through push/full and results leave through empty/pop, one
// result per request, in order. The modulus register sits at byte address 0 of
// the APB-style port and resets to 1000000007; reads return it.
// A front stage classifies each request and places it in a two-entry queue;
// the back unit runs one request at a time. The back unit first reduces both
// operands, then finishes add or subtract. Multiply adds a pass of the
// bit-serial shift-and-add multiplier. Power takes 32 exponent steps, each a
// step state and a square, with a multiply before the square where the
// exponent bit is set; divide raises the divisor to the modulus minus 2 the
// same way, then adds a final multiply. The top bit of the divide exponent
// is always zero. A zero divisor or a modulus of 1 gives a zero result.
// After reset the queue is empty and the unit idle. While the receiver does
// not pop, the result stays on the port, the back unit holds, and the queue and
// front fill up; full is high whenever the front holds a request.
`default_nettype none
module modular_arithmetic_unit import mau_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [2:0] req_type,
	input wire logic [RW-1:0] operand_a,
	input wire logic [EW-1:0] operand_b,
	output logic empty,
	input wire logic pop,
	output logic [RW-1:0] result,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [RW-1:0] modulus_q;
	logic q_push, q_full, q_rd, q_empty;
	job_t q_in, q_out;
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {1'b0, modulus_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) modulus_q <= MOD_RESET;
		else if (psel && penable && pwrite && paddr == 2'd0) modulus_q <= pwdata[RW-1:0];
	end
	mau_front u_front (.clk, .arst_n, .push, .full, .req_type, .operand_a, .operand_b,
		.q_push, .q_full, .q_job(q_in));
	mau_queue u_queue (.clk, .arst_n, .wr(q_push), .qfull(q_full), .wdata(q_in),
		.rd(q_rd), .qempty(q_empty), .rdata(q_out));
	mau_back u_back (.clk, .arst_n, .modulus(modulus_q), .qempty(q_empty), .job(q_out),
		.rd(q_rd), .empty, .pop, .result);
endmodule
`default_nettype wire

// ===== hw/rtl/mau_front.sv =====
// Front part: accepts requests and classifies each by operation.
// Depends on mau_pkg.
`default_nettype none
module mau_front import mau_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [2:0] req_type,
	input wire logic [RW-1:0] operand_a,
	input wire logic [EW-1:0] operand_b,
	output logic q_push,
	input wire logic q_full,
	output job_t q_job
);
	logic v_q;
	job_t j_q;
	job_t j_d;
	always_comb begin
		j_d.a = operand_a;
		j_d.b = operand_b;
		j_d.r = '0;
		case (req_type)
			OP_ADD, OP_SUB: j_d.cls = CL_DIRECT;
			OP_MUL: j_d.cls = CL_MUL;
			OP_DIV: j_d.cls = CL_DIV;
			OP_POW: j_d.cls = CL_POW;
			default: j_d.cls = CL_DIRECT;
		endcase
		j_d.r[1:0] = (req_type == OP_ADD) ? 2'd1 : (req_type == OP_SUB) ? 2'd2 : 2'd0;
	end
	assign full = v_q;
	assign q_push = v_q && !q_full;
	assign q_job = j_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (push && !v_q) begin
			v_q <= 1'b1;
		end else if (q_push) begin
			v_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (push && !v_q) begin
			j_q <= j_d;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/mau_queue.sv =====
// Short queue of classified jobs between front and back.
// Depends on mau_pkg.
`default_nettype none
module mau_queue import mau_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr,
	output logic qfull,
	input wire job_t wdata,
	input wire logic rd,
	output logic qempty,
	output job_t rdata
);
	job_t mem_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	assign qfull = cnt_q == 2'(QDEPTH);
	assign qempty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/mau_back.sv =====
// Back part: reduces operands, runs a bit-serial modular multiplier and the
// square-and-multiply sequencer, and holds the result. Depends on mau_pkg.
`default_nettype none
module mau_back import mau_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [RW-1:0] modulus,
	input wire logic qempty,
	input wire job_t job,
	output logic rd,
	output logic empty,
	input wire logic pop,
	output logic [RW-1:0] result
);
	st_t st_q, st_d;
	logic [RW:0] m;
	logic [EW-1:0] e_q;
	logic [RW:0] a_q, b_q, acc_q, base_q, x_q, y_q, p_q, pa_q;
	logic [1:0] sub_q;
	cls_t cls_q;
	logic [6:0] i_q;
	logic [6:0] ecnt_q;
	logic [EW-1:0] bred_q;
	logic [EW-1:0] ared_q;
	logic [RW:0] res_q;
	logic [RW+1:0] dbl, dadd;
	logic [RW:0] dbl_r, add_r;
	assign m = (modulus < RW'(2)) ? (RW+1)'(1) : {1'b0, modulus};
	assign dbl = {1'b0, p_q} + {1'b0, p_q};
	assign dbl_r = (dbl >= {1'b0, m}) ? (RW+1)'(dbl - {1'b0, m}) : dbl[RW:0];
	assign dadd = {1'b0, dbl_r} + {1'b0, x_q};
	assign add_r = (dadd >= {1'b0, m}) ? (RW+1)'(dadd - {1'b0, m}) : dadd[RW:0];
	logic [RW+1:0] s2;
	logic [RW:0] addres, subres;
	assign s2 = {1'b0, a_q} + {1'b0, b_q};
	assign addres = (s2 >= {1'b0, m}) ? (RW+1)'(s2 - {1'b0, m}) : s2[RW:0];
	assign subres = (a_q >= b_q) ? a_q - b_q : a_q + m - b_q;
	logic mdone;
	assign mdone = i_q == 7'd0;
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (!qempty) st_d = ST_RA;
			ST_RA: st_d = ST_RB;
			ST_RB: if (i_q == 7'd0) st_d = ST_DISP;
			ST_DISP: begin
				case (cls_q)
					CL_MUL: st_d = ST_MUL;
					CL_POW, CL_DIV: st_d = ST_PSTEP;
					default: st_d = ST_DONE;
				endcase
				if (cls_q == CL_DIV && (b_q == '0 || m == (RW+1)'(1))) st_d = ST_DONE;
			end
			ST_MUL, ST_DIVMUL: if (mdone) st_d = ST_DONE;
			ST_PSTEP: begin
				if (ecnt_q == 7'd0) st_d = (cls_q == CL_DIV) ? ST_DIVMUL : ST_DONE;
				else if (e_q[0]) st_d = ST_PMUL;
				else st_d = ST_PSQR;
			end
			ST_PMUL: if (mdone) st_d = ST_PSQR;
			ST_PSQR: if (mdone) st_d = ST_PSTEP;
			ST_DONE: if (pop) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end
	assign rd = (st_q == ST_IDLE) && !qempty;
	assign empty = st_q != ST_DONE;
	assign result = res_q[RW-1:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				a_q <= {1'b0, job.a};
				ared_q <= EW'(job.a);
				bred_q <= job.b;
				b_q <= {1'b0, job.b[EW-1:0] > EW'({1'b0, {RW{1'b1}}}) ? {RW{1'b1}}
					: job.b[RW-1:0]};
				e_q <= job.b;
				cls_q <= job.cls;
				sub_q <= job.r[1:0];
				ecnt_q <= 7'(EW);
			end
			ST_RA: begin
				// Reduce both operands one shifted bit per cycle.
				b_q <= '0;
				p_q <= '0;
				pa_q <= '0;
				i_q <= 7'(EW);
			end
			ST_RB: begin
				if (i_q != 7'd0) begin
					p_q <= ({1'b0, p_q, bred_q[EW-1]} >= {2'b0, m}) ?
						(RW+1)'({1'b0, p_q, bred_q[EW-1]} - {2'b0, m}) :
						(RW+1)'({p_q, bred_q[EW-1]});
					pa_q <= ({1'b0, pa_q, ared_q[EW-1]} >= {2'b0, m}) ?
						(RW+1)'({1'b0, pa_q, ared_q[EW-1]} - {2'b0, m}) :
						(RW+1)'({pa_q, ared_q[EW-1]});
					bred_q <= {bred_q[EW-2:0], 1'b0};
					ared_q <= {ared_q[EW-2:0], 1'b0};
					i_q <= i_q - 7'd1;
					b_q <= '0;
				end else begin
					b_q <= p_q;
					a_q <= pa_q;
				end
			end
			ST_DISP: begin
				acc_q <= (m == (RW+1)'(1)) ? '0 : (RW+1)'(1);
				x_q <= a_q;
				y_q <= b_q;
				p_q <= '0;
				i_q <= 7'(RW + 1);
				res_q <= (cls_q != CL_DIRECT) ? '0 : (sub_q == 2'd1) ? addres :
					(sub_q == 2'd2) ? subres : '0;
				if (cls_q == CL_POW) begin
					base_q <= a_q;
				end else begin
					base_q <= b_q;
					e_q <= EW'(m - (RW+1)'(2));
				end
			end
			ST_MUL, ST_PMUL, ST_PSQR, ST_DIVMUL: begin
				if (!mdone) begin
					p_q <= y_q[RW] ? add_r : dbl_r;
					y_q <= {y_q[RW-1:0], 1'b0};
					i_q <= i_q - 7'd1;
				end else begin
					case (st_q)
						ST_MUL, ST_DIVMUL: res_q <= p_q;
						ST_PMUL: acc_q <= p_q;
						default: begin
							base_q <= p_q;
							e_q <= {1'b0, e_q[EW-1:1]};
							ecnt_q <= ecnt_q - 7'd1;
						end
					endcase
					p_q <= '0;
					i_q <= 7'(RW + 1);
					if (st_q == ST_PMUL) begin
						x_q <= base_q;
						y_q <= base_q;
					end
				end
			end
			ST_PSTEP: begin
				p_q <= '0;
				i_q <= 7'(RW + 1);
				if (ecnt_q == 7'd0) begin
					res_q <= acc_q;
					x_q <= a_q;
					y_q <= acc_q;
				end else if (e_q[0]) begin
					x_q <= acc_q;
					y_q <= base_q;
				end else begin
					x_q <= base_q;
					y_q <= base_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/mau_checker.sv =====
// Port checker for the modular arithmetic unit, bound to the top level.
// Depends on mau_pkg.
`default_nettype none
module mau_checker import mau_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire logic pop,
	input wire logic [RW-1:0] result,
	input wire logic pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result)) else $error("result dropped");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop |=> empty) else $error("result repeated");
endmodule
bind modular_arithmetic_unit mau_checker u_chk (.clk, .arst_n, .empty, .pop, .result,
	.pready);
`default_nettype wire

// ===== tb/modular_arithmetic_unit_chk.sv =====
// Checker for the modular arithmetic unit: predicts each result residue and compares.
// Depends on mau_pkg; watches the request and result channels of the unit.
`default_nettype none
module modular_arithmetic_unit_chk import mau_pkg::*; (
	input wire logic clk,
	input wire logic push,
	input wire logic full,
	input wire logic [2:0] req_type,
	input wire logic [RW-1:0] operand_a,
	input wire logic [EW-1:0] operand_b,
	input wire logic empty,
	input wire logic pop,
	input wire logic [RW-1:0] result,
	input wire logic [RW-1:0] modulus,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [RW-1:0] residue_q[$];

	function automatic logic [63:0] madd(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		logic [63:0] s;
		s = x + y;
		return (s >= m) ? s - m : s;
	endfunction

	function automatic logic [63:0] mmul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		logic [63:0] acc;
		acc = 0;
		for (int i = 63; i >= 0; i--) begin
			acc = madd(acc, acc, m);
			if (y[i]) acc = madd(acc, x, m);
		end
		return acc;
	endfunction

	function automatic logic [63:0] mpow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1 % m;
		for (int i = 0; i < 64; i++) begin
			if (e[i]) acc = mmul(acc, base, m);
			base = mmul(base, base, m);
		end
		return acc;
	endfunction

	function automatic logic [RW-1:0] predict_residue(logic [2:0] op, logic [RW-1:0] ra,
			logic [EW-1:0] rb, logic [RW-1:0] md);
		logic [63:0] m, a, b, r;
		m = (md < 2) ? 64'd1 : 64'(md);
		a = 64'(ra) % m;
		b = 64'(rb) % m;
		case (op)
			OP_ADD: r = madd(a, b, m);
			OP_SUB: r = (a >= b) ? a - b : a + m - b;
			OP_MUL: r = mmul(a, b, m);
			OP_DIV: r = (b != 0 && m >= 2) ? mmul(a, mpow(b, m - 2, m), m) : 64'd0;
			OP_POW: r = mpow(a, 64'(rb), m);
			default: r = 0;
		endcase
		return r[RW-1:0];
	endfunction

	initial errors = 0;
	assign pending = residue_q.size();

	always @(posedge clk) begin
		if (push && !full)
			residue_q.push_back(predict_residue(req_type, operand_a, operand_b, modulus));
		if (pop && !empty) begin
			if (residue_q.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %0d", $time, result);
				errors++;
			end else begin
				if (result !== residue_q[0]) begin
					$display("%0t: result mismatch, expected %0d, actual %0d",
						$time, residue_q[0], result);
					errors++;
				end
				void'(residue_q.pop_front());
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/modular_arithmetic_unit_tb.sv =====
// Testbench top for the modular arithmetic unit: clock, reset, stimulus and verdict.
// Depends on mau_pkg, modular_arithmetic_unit and modular_arithmetic_unit_chk.
`default_nettype none
module modular_arithmetic_unit_tb;
	import mau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 40000;

	logic clk = 0, arst_n = 0;
	logic push = 0, pop = 0;
	logic [2:0] req_type = 0;
	logic [RW-1:0] operand_a = 0;
	logic [EW-1:0] operand_b = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [1:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic full, empty, pready;
	logic [RW-1:0] result;
	logic [31:0] prdata;
	logic [RW-1:0] modulus = MOD_RESET;
	int errors, pending;
	int idle_cycles = 0;
	logic stall_burst = 0;

	always #1 clk = ~clk;

	modular_arithmetic_unit u_dut (.*);

	modular_arithmetic_unit_chk u_chk (.clk, .push, .full, .req_type, .operand_a,
		.operand_b, .empty, .pop, .result, .modulus, .errors, .pending);

	always @(posedge clk) begin
		if ($urandom_range(0, 99) < 3) stall_burst <= ~stall_burst;
		pop <= stall_burst ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("modular_arithmetic_unit test failed");
			$finish;
		end
	end

	task automatic send_request(logic [2:0] op, logic [RW-1:0] a, logic [EW-1:0] b);
		push <= 1;
		req_type <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic pause_sender(int n);
		push <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic write_modulus(logic [RW-1:0] m);
		psel <= 1;
		pwrite <= 1;
		paddr <= 0;
		pwdata <= 32'(m);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		modulus = m;
	endtask

	task automatic drain_results();
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [EW-1:0] rand_exponent();
		case ($urandom_range(0, 3))
			0: return EW'($urandom_range(0, 15));
			1: return EW'($urandom_range(0, 1000));
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int n);
		int left;
		logic [2:0] op;
		logic [RW-1:0] a;
		logic [EW-1:0] b;
		left = n;
		while (left > 0) begin
			for (int k = $urandom_range(1, 8); k > 0 && left > 0; k--) begin
				op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
					: 3'($urandom_range(0, 4));
				if ($urandom_range(0, 9) == 0) begin
					a = RW'($urandom);
					b = $urandom;
				end else begin
					a = RW'($urandom % ((modulus < 2) ? 1 : modulus));
					b = (op == OP_POW) ? rand_exponent()
						: EW'($urandom % ((modulus < 2) ? 1 : modulus));
				end
				send_request(op, a, b);
				left--;
			end
			if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_request(OP_ADD, RW'(MOD_RESET - 1), EW'(MOD_RESET - 1));
		send_request(OP_ADD, 0, 0);
		send_request(OP_SUB, 0, EW'(MOD_RESET - 1));
		send_request(OP_SUB, 5, 3);
		send_request(OP_MUL, RW'(MOD_RESET - 1), EW'(MOD_RESET - 1));
		send_request(OP_MUL, '1, '1);
		send_request(OP_DIV, 12345, 0);
		send_request(OP_DIV, 10, 5);
		send_request(OP_DIV, RW'(MOD_RESET - 1), EW'(MOD_RESET - 1));
		send_request(OP_POW, 0, 0);
		send_request(OP_POW, 7, 0);
		send_request(OP_POW, RW'(MOD_RESET - 1), '1);
		send_request(OP_POW, 3, 32'h8000_0000);
		send_request(3'd5, 1, 1);
		send_request(3'd6, '1, '1);
		send_request(3'd7, 2, 2);
		send_request(OP_ADD, MOD_RESET, EW'(MOD_RESET));
		drain_results();
		random_phase(70);
		drain_results();
		write_modulus(RW'(2147483647));
		send_request(OP_ADD, '1, '1);
		send_request(OP_DIV, RW'(2147483646), '1);
		random_phase(60);
		drain_results();
		write_modulus(2);
		random_phase(30);
		drain_results();
		write_modulus(0);
		send_request(OP_POW, 5, 0);
		random_phase(15);
		drain_results();
		write_modulus(1);
		random_phase(10);
		drain_results();
		write_modulus(RW'(1000));
		random_phase(30);
		drain_results();
		write_modulus(RW'(65521));
		random_phase(60);
		drain_results();
		if (errors == 0)
			$display("modular_arithmetic_unit test passed");
		else
			$display("modular_arithmetic_unit test failed");
		$finish;
	end
endmodule
`default_nettype wire
